### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the synchronous AM demodulator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SAMD_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define SAMD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define SAMD_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define SAMD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/samd_pkg.sv
// Types, constants, tables and helper functions of the synchronous AM demodulator.
`default_nettype none
package samd_pkg;
	localparam int SAMPLE_BITS   = 16;
	localparam int INTERNAL_BITS = 24;
	localparam int IFRAC         = INTERNAL_BITS - 4;
	localparam int IN_SHIFT      = IFRAC - (SAMPLE_BITS - 1);
	localparam int TRIG_FRAC     = 22;
	localparam int Q24_SHIFT     = 24;
	localparam int HILBERT_STAGES = 7;
	localparam int CORDIC_ITERS  = 20;
	localparam int WIDE_W        = 52;
	localparam int CORDIC_W      = 27;
	localparam int MUL_W         = 26;
	localparam int PHASE_W       = 24;

	typedef logic signed [INTERNAL_BITS-1:0] ival_t;
	typedef logic signed [WIDE_W-1:0]        wide_t;
	typedef logic signed [CORDIC_W-1:0]      cval_t;
	typedef logic signed [MUL_W-1:0]         mop_t;
	typedef logic signed [SAMPLE_BITS-1:0]   samp_t;

	localparam cval_t CORDIC_K  = 27'sd2547003;
	localparam cval_t HALF_TURN = 27'sd8388608;
	localparam mop_t  DC_POLE   = 26'sd16609444;

	localparam logic [2:0] MODE_SYNC     = 3'd0;
	localparam logic [2:0] MODE_USB      = 3'd1;
	localparam logic [2:0] MODE_LSB      = 3'd2;
	localparam logic [2:0] MODE_STEREO   = 3'd3;
	localparam logic [2:0] MODE_CQUAM    = 3'd4;
	localparam logic [2:0] MODE_NULL_LSB = 3'd5;
	localparam logic [2:0] MODE_NULL_USB = 3'd6;
	localparam logic [2:0] MODE_ALIAS    = 3'd7;

	localparam logic [2:0] REG_MODE   = 3'd0;
	localparam logic [2:0] REG_FADE   = 3'd1;
	localparam logic [2:0] REG_DC     = 3'd2;
	localparam logic [2:0] REG_GPROP  = 3'd3;
	localparam logic [2:0] REG_GINT   = 3'd4;
	localparam logic [2:0] REG_FLIMIT = 3'd5;
	localparam logic [2:0] REG_FFAST  = 3'd6;
	localparam logic [2:0] REG_FSLOW  = 3'd7;

	typedef enum logic [3:0] {
		S_IDLE, S_SINCOS, S_DEROT, S_CHAIN, S_FORM, S_LEVEL, S_ATAN, S_LOOP, S_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_AVG_FAST0, OP_AVG_SLOW0, OP_MIX0, OP_DC0,
		OP_AVG_FAST1, OP_AVG_SLOW1, OP_MIX1, OP_DC1, OP_DC_NULL
	} lvl_op_t;

	function automatic ival_t isat(input wide_t v);
		wide_t hi;
		wide_t lo;
		hi = (wide_t'(1) <<< (INTERNAL_BITS - 1)) - wide_t'(1);
		lo = -hi - wide_t'(1);
		if (v > hi) return ival_t'(hi[INTERNAL_BITS-1:0]);
		if (v < lo) return ival_t'(lo[INTERNAL_BITS-1:0]);
		return ival_t'(v[INTERNAL_BITS-1:0]);
	endfunction

	function automatic samp_t to_out(input ival_t v);
		ival_t s;
		ival_t hi;
		ival_t lo;
		s  = v >>> IN_SHIFT;
		hi = (ival_t'(1) <<< (SAMPLE_BITS - 1)) - ival_t'(1);
		lo = -hi - ival_t'(1);
		if (s > hi) return samp_t'(hi[SAMPLE_BITS-1:0]);
		if (s < lo) return samp_t'(lo[SAMPLE_BITS-1:0]);
		return samp_t'(s[SAMPLE_BITS-1:0]);
	endfunction

	function automatic cval_t atan_entry(input logic [4:0] idx);
		case (idx)
			5'd0:  return 27'sd2097152;
			5'd1:  return 27'sd1238021;
			5'd2:  return 27'sd654136;
			5'd3:  return 27'sd332050;
			5'd4:  return 27'sd166669;
			5'd5:  return 27'sd83416;
			5'd6:  return 27'sd41718;
			5'd7:  return 27'sd20860;
			5'd8:  return 27'sd10430;
			5'd9:  return 27'sd5215;
			5'd10: return 27'sd2608;
			5'd11: return 27'sd1304;
			5'd12: return 27'sd652;
			5'd13: return 27'sd326;
			5'd14: return 27'sd163;
			5'd15: return 27'sd81;
			5'd16: return 27'sd41;
			5'd17: return 27'sd20;
			5'd18: return 27'sd10;
			5'd19: return 27'sd5;
			default: return 27'sd0;
		endcase
	endfunction

	function automatic mop_t allpass_coef(input logic odd, input logic [2:0] idx);
		if (odd) begin
			case (idx)
				3'd0: return -26'sd1663005;
				3'd1: return -26'sd9489524;
				3'd2: return -26'sd14385911;
				3'd3: return -26'sd16091429;
				3'd4: return -26'sd16588294;
				3'd5: return -26'sd16726200;
				3'd6: return -26'sd16765178;
				default: return 26'sd0;
			endcase
		end
		case (idx)
			3'd0: return -26'sd5506315;
			3'd1: return -26'sd12485126;
			3'd2: return -26'sd15485755;
			3'd3: return -26'sd16416346;
			3'd4: return -26'sd16678705;
			3'd5: return -26'sd16751362;
			3'd6: return -26'sd16773698;
			default: return 26'sd0;
		endcase
	endfunction
endpackage
`default_nettype wire

### rtl/synchronous_am_demodulator.sv
// Synchronous AM demodulator: PLL derotation, allpass sideband split, audio and loop update.
// The input side is busy during the whole item: a new sample is taken only in the idle state.
// Processing is ordered around the single shared 26x26 multiplier (product registered in p_q)
// and the shared 20-step CORDIC (sin/cos and atan2).
// A finished beat waits in an output register while the next input is accepted.
// Reset (arst_n low) clears all loop, filter, averager and tap state and the registers.
`default_nettype none
`include "assert_macros.svh"
module synchronous_am_demodulator
	import samd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // in_i [15:0], in_q [31:16]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,   // out_mono, out_left, out_right, freq_word [71:48]
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	state_t st_q, st_d;
	logic [4:0] cnt_q;
	logic       ph_q;
	logic [1:0] chain_q;

	logic [2:0]  mode_q;
	logic        fade_en_q, dc_en_q;
	logic [23:0] gprop_q, gint_q, ffast_q, fslow_q;
	logic [22:0] flim_q;

	logic [PHASE_W-1:0] phase_q;
	ival_t freq_q, filt_q;
	ival_t ii_q, qq_q;
	cval_t cx_q, cy_q, cz_q;
	logic  rot_q, zero_q;
	ival_t ai_q, bi_q, aq_q, bq_q, dly_i_q, dly_q_q;
	ival_t d1_q [4][8];
	ival_t d2_q [4][8];
	ival_t cur_q;
	ival_t ps_q [4];
	ival_t corr_i_q, corr_q_q, aud_q, audu_q, audn_q;
	ival_t fav_q [4];
	ival_t dcm_q [3];
	wide_t p_q;
	logic        m_tvalid_q;
	logic [71:0] m_tdata_q;

	logic [2:0] mode_e;
	logic hil_on, stereo, nullm;
	cval_t xs, ys, c_w, s_w;
	logic  pos;
	mop_t  mul_a, mul_b;
	wide_t p_w;
	ival_t det_w;
	ival_t rot_d1 [8];
	ival_t rot_d2 [8];
	ival_t next_in;
	logic  op_en;
	lvl_op_t op;
	ival_t corr_i_w, corr_q_w, lsb_w, usb_w, ps0, ps1, ps2, ps3;
	wide_t fsum, flim_w, fclamp;
	ival_t z0_w;
	logic  wr_en;

	assign wr_en  = psel && penable && pwrite && pready;
	assign mode_e = (mode_q == MODE_ALIAS) ? MODE_SYNC : mode_q;
	assign hil_on = (mode_e != MODE_SYNC) && (mode_e != MODE_CQUAM);
	assign stereo = mode_e inside {MODE_STEREO, MODE_CQUAM, MODE_NULL_LSB, MODE_NULL_USB};
	assign nullm  = mode_e inside {MODE_NULL_LSB, MODE_NULL_USB};
	assign op     = lvl_op_t'(cnt_q[3:0]);

	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE:   if (s_tvalid) st_d = S_SINCOS;
			S_SINCOS: if (cnt_q == 5'(CORDIC_ITERS - 1)) st_d = S_DEROT;
			S_DEROT:  if (cnt_q == 5'd3 && ph_q) st_d = hil_on ? S_CHAIN : S_FORM;
			S_CHAIN:  if (cnt_q == 5'(HILBERT_STAGES) && chain_q == 2'd3) st_d = S_FORM;
			S_FORM:   st_d = S_LEVEL;
			S_LEVEL:  if (op == OP_DC_NULL && ph_q) st_d = S_ATAN;
			S_ATAN:   if (cnt_q == 5'(CORDIC_ITERS - 1)) st_d = S_LOOP;
			S_LOOP:   if (cnt_q == 5'd1 && ph_q) st_d = S_DONE;
			S_DONE:   if (!m_tvalid_q || m_tready) st_d = S_IDLE;
			default:  st_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (st_q == S_IDLE);
		m_tvalid = m_tvalid_q;
		m_tdata  = m_tdata_q;
		pready   = 1'b1;
		case (paddr[4:2])
			REG_MODE:   prdata = {29'd0, mode_q};
			REG_FADE:   prdata = {31'd0, fade_en_q};
			REG_DC:     prdata = {31'd0, dc_en_q};
			REG_GPROP:  prdata = {8'd0, gprop_q};
			REG_GINT:   prdata = {8'd0, gint_q};
			REG_FLIMIT: prdata = {9'd0, flim_q};
			REG_FFAST:  prdata = {8'd0, ffast_q};
			REG_FSLOW:  prdata = {8'd0, fslow_q};
			default:    prdata = 32'd0;
		endcase
	end

	always_comb begin
		xs  = cx_q >>> cnt_q;
		ys  = cy_q >>> cnt_q;
		pos = rot_q ? !cz_q[CORDIC_W-1] : !(cy_q > cval_t'(0));
		case (phase_q[PHASE_W-1:PHASE_W-2])
			2'd0:    begin c_w = cx_q;  s_w = cy_q;  end
			2'd1:    begin c_w = -cy_q; s_w = cx_q;  end
			2'd2:    begin c_w = -cx_q; s_w = -cy_q; end
			default: begin c_w = cy_q;  s_w = -cx_q; end
		endcase
		det_w = zero_q ? ival_t'(0) : isat(wide_t'(cz_q));
		for (int m = 0; m < 7; m++) begin
			rot_d1[m] = d1_q[0][m+1];
			rot_d2[m] = d2_q[0][m+1];
		end
		rot_d1[7] = cur_q;
		rot_d2[7] = d1_q[0][0];
		case (chain_q)
			2'd0:    next_in = bi_q;
			2'd1:    next_in = dly_q_q;
			default: next_in = aq_q;
		endcase
		ps0 = hil_on ? ps_q[0] : ival_t'(0);
		ps1 = hil_on ? ps_q[1] : ival_t'(0);
		ps2 = hil_on ? ps_q[2] : ival_t'(0);
		ps3 = hil_on ? ps_q[3] : ival_t'(0);
		corr_i_w = isat(wide_t'(ai_q) + wide_t'(bq_q));
		corr_q_w = isat(wide_t'(aq_q) - wide_t'(bi_q));
		lsb_w = isat((wide_t'(ps0) + wide_t'(ps1)) - (wide_t'(ps3) - wide_t'(ps2)));
		usb_w = isat((wide_t'(ps0) - wide_t'(ps1)) + (wide_t'(ps3) + wide_t'(ps2)));
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			S_DEROT: begin
				mul_a = cnt_q[0] ? mop_t'(s_w) : mop_t'(c_w);
				mul_b = cnt_q[1] ? mop_t'(qq_q) : mop_t'(ii_q);
			end
			S_CHAIN: begin
				mul_a = allpass_coef(chain_q[0], cnt_q[2:0]);
				mul_b = mop_t'(cur_q) - mop_t'(d2_q[0][1]);
			end
			S_LEVEL: begin
				case (op)
					OP_AVG_FAST0: begin
						mul_a = mop_t'({1'b0, ffast_q});
						mul_b = mop_t'(fav_q[0]) - mop_t'(aud_q);
					end
					OP_AVG_SLOW0: begin
						mul_a = mop_t'({1'b0, fslow_q});
						mul_b = mop_t'(fav_q[1]) - mop_t'(corr_i_q);
					end
					OP_DC0: begin
						mul_a = DC_POLE;
						mul_b = mop_t'(dcm_q[0]);
					end
					OP_AVG_FAST1: begin
						mul_a = mop_t'({1'b0, ffast_q});
						mul_b = mop_t'(fav_q[2]) - mop_t'(audu_q);
					end
					OP_AVG_SLOW1: begin
						mul_a = mop_t'({1'b0, fslow_q});
						mul_b = mop_t'(fav_q[3]) - mop_t'(corr_i_q);
					end
					OP_DC1: begin
						mul_a = DC_POLE;
						mul_b = mop_t'(dcm_q[1]);
					end
					OP_DC_NULL: begin
						mul_a = DC_POLE;
						mul_b = mop_t'(dcm_q[2]);
					end
					default: begin
						mul_a = '0;
						mul_b = '0;
					end
				endcase
			end
			S_LOOP: begin
				mul_a = cnt_q[0] ? mop_t'({1'b0, gprop_q}) : mop_t'({1'b0, gint_q});
				mul_b = mop_t'(det_w);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		p_w = wide_t'(mul_a) * wide_t'(mul_b);
		case (op)
			OP_AVG_FAST0, OP_AVG_SLOW0, OP_MIX0: op_en = fade_en_q;
			OP_DC0:                              op_en = dc_en_q;
			OP_AVG_FAST1, OP_AVG_SLOW1, OP_MIX1: op_en = stereo && fade_en_q;
			OP_DC1:                              op_en = stereo && dc_en_q;
			OP_DC_NULL:                          op_en = nullm && dc_en_q;
			default:                             op_en = 1'b0;
		endcase
		case (op)
			OP_DC0:  z0_w = isat(wide_t'(aud_q) + (p_q >>> Q24_SHIFT));
			OP_DC1:  z0_w = isat(wide_t'(audu_q) + (p_q >>> Q24_SHIFT));
			default: z0_w = isat(wide_t'(audn_q) + (p_q >>> Q24_SHIFT));
		endcase
		fsum   = wide_t'(freq_q) + (p_q >>> Q24_SHIFT);
		flim_w = wide_t'({1'b0, flim_q});
		if (fsum > flim_w) fclamp = flim_w;
		else if (fsum < -flim_w) fclamp = -flim_w;
		else fclamp = fsum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SYNC;
			fade_en_q <= 1'b0;
			dc_en_q <= 1'b0;
			gprop_q <= '0;
			gint_q <= '0;
			flim_q <= 23'h7FFFFF;
			ffast_q <= '0;
			fslow_q <= '0;
		end else if (wr_en) begin
			case (paddr[4:2])
				REG_MODE:   mode_q <= pwdata[2:0];
				REG_FADE:   fade_en_q <= pwdata[0];
				REG_DC:     dc_en_q <= pwdata[0];
				REG_GPROP:  gprop_q <= pwdata[23:0];
				REG_GINT:   gint_q <= pwdata[23:0];
				REG_FLIMIT: flim_q <= pwdata[22:0];
				REG_FFAST:  ffast_q <= pwdata[23:0];
				REG_FSLOW:  fslow_q <= pwdata[23:0];
				default:    mode_q <= mode_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		p_q <= p_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
			ph_q <= 1'b0;
			chain_q <= '0;
			phase_q <= '0;
			freq_q <= '0;
			filt_q <= '0;
			dly_i_q <= '0;
			dly_q_q <= '0;
			for (int c = 0; c < 4; c++) begin
				for (int m = 0; m < 8; m++) begin
					d1_q[c][m] <= '0;
					d2_q[c][m] <= '0;
				end
				fav_q[c] <= '0;
				ps_q[c] <= '0;
			end
			for (int k = 0; k < 3; k++) dcm_q[k] <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q <= '0;
			rot_q <= 1'b1;
			zero_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (m_tvalid_q && m_tready && st_q != S_DONE) m_tvalid_q <= 1'b0;
			if (st_d != st_q) begin
				cnt_q <= '0;
				ph_q <= 1'b0;
			end else if (st_q == S_SINCOS || st_q == S_ATAN) begin
				cnt_q <= cnt_q + 5'd1;
			end else if (st_q == S_CHAIN && cnt_q == 5'(HILBERT_STAGES)) begin
				cnt_q <= '0;
				ph_q <= 1'b0;
			end else begin
				ph_q <= !ph_q;
				if (ph_q) cnt_q <= cnt_q + 5'd1;
			end
			case (st_q)
				S_IDLE: begin
					if (s_tvalid) begin
						ii_q <= ival_t'(samp_t'(s_tdata[15:0])) <<< IN_SHIFT;
						qq_q <= ival_t'(samp_t'(s_tdata[31:16])) <<< IN_SHIFT;
						cx_q <= CORDIC_K;
						cy_q <= '0;
						cz_q <= cval_t'(phase_q[PHASE_W-3:0]);
						rot_q <= 1'b1;
						zero_q <= 1'b0;
					end
				end
				S_SINCOS, S_ATAN: begin
					if (pos) begin
						cx_q <= cx_q - ys;
						cy_q <= cy_q + xs;
						cz_q <= cz_q - atan_entry(cnt_q);
					end else begin
						cx_q <= cx_q + ys;
						cy_q <= cy_q - xs;
						cz_q <= cz_q + atan_entry(cnt_q);
					end
				end
				S_DEROT: begin
					if (ph_q) begin
						case (cnt_q[1:0])
							2'd0:    ai_q <= isat(p_q >>> TRIG_FRAC);
							2'd1:    bi_q <= isat(p_q >>> TRIG_FRAC);
							2'd2:    aq_q <= isat(p_q >>> TRIG_FRAC);
							default: bq_q <= isat(p_q >>> TRIG_FRAC);
						endcase
					end
					chain_q <= '0;
					cur_q <= dly_i_q;
				end
				S_CHAIN: begin
					if (cnt_q == 5'(HILBERT_STAGES)) begin
						ps_q[chain_q] <= cur_q;
						for (int c = 0; c < 3; c++) begin
							d1_q[c] <= d1_q[c+1];
							d2_q[c] <= d2_q[c+1];
						end
						d1_q[3] <= rot_d1;
						d2_q[3] <= rot_d2;
						chain_q <= chain_q + 2'd1;
						cur_q <= next_in;
						if (chain_q == 2'd3) begin
							dly_i_q <= ai_q;
							dly_q_q <= bq_q;
						end
					end else if (ph_q) begin
						d1_q[0] <= rot_d1;
						d2_q[0] <= rot_d2;
						cur_q <= isat((p_q >>> Q24_SHIFT) + wide_t'(d2_q[0][0]));
					end
				end
				S_FORM: begin
					corr_i_q <= corr_i_w;
					corr_q_q <= corr_q_w;
					audu_q <= '0;
					audn_q <= '0;
					case (mode_e)
						MODE_USB: aud_q <= usb_w;
						MODE_LSB: aud_q <= lsb_w;
						MODE_STEREO: begin
							aud_q <= lsb_w;
							audu_q <= usb_w;
						end
						MODE_CQUAM: begin
							aud_q <= isat(wide_t'(corr_i_w) + wide_t'(corr_q_w));
							audu_q <= isat(wide_t'(corr_i_w) - wide_t'(corr_q_w));
						end
						MODE_NULL_LSB: begin
							aud_q <= lsb_w;
							audu_q <= usb_w;
							audn_q <= isat(wide_t'(lsb_w) - wide_t'(usb_w));
						end
						MODE_NULL_USB: begin
							aud_q <= lsb_w;
							audu_q <= usb_w;
							audn_q <= isat(wide_t'(usb_w) - wide_t'(lsb_w));
						end
						default: aud_q <= corr_i_w;
					endcase
				end
				S_LEVEL: begin
					if (ph_q && op_en) begin
						case (op)
							OP_AVG_FAST0:
								fav_q[0] <= isat(wide_t'(aud_q) + (p_q >>> Q24_SHIFT));
							OP_AVG_SLOW0:
								fav_q[1] <= isat(wide_t'(corr_i_q) + (p_q >>> Q24_SHIFT));
							OP_MIX0:
								aud_q <= isat(wide_t'(aud_q) + wide_t'(fav_q[1])
									- wide_t'(fav_q[0]));
							OP_DC0: begin
								aud_q <= isat(wide_t'(z0_w) - wide_t'(dcm_q[0]));
								dcm_q[0] <= z0_w;
							end
							OP_AVG_FAST1:
								fav_q[2] <= isat(wide_t'(audu_q) + (p_q >>> Q24_SHIFT));
							OP_AVG_SLOW1:
								fav_q[3] <= isat(wide_t'(corr_i_q) + (p_q >>> Q24_SHIFT));
							OP_MIX1:
								audu_q <= isat(wide_t'(audu_q) + wide_t'(fav_q[3])
									- wide_t'(fav_q[2]));
							OP_DC1: begin
								audu_q <= isat(wide_t'(z0_w) - wide_t'(dcm_q[1]));
								dcm_q[1] <= z0_w;
							end
							OP_DC_NULL: begin
								audn_q <= isat(wide_t'(z0_w) - wide_t'(dcm_q[2]));
								dcm_q[2] <= z0_w;
							end
							default: aud_q <= aud_q;
						endcase
					end
					if (st_d == S_ATAN) begin
						rot_q <= 1'b0;
						zero_q <= (corr_i_q == '0) && (corr_q_q == '0);
						if (corr_i_q < 0) begin
							cx_q <= -cval_t'(corr_i_q);
							cy_q <= -cval_t'(corr_q_q);
							cz_q <= (corr_q_q >= 0) ? HALF_TURN : -HALF_TURN;
						end else begin
							cx_q <= cval_t'(corr_i_q);
							cy_q <= cval_t'(corr_q_q);
							cz_q <= '0;
						end
					end
				end
				S_LOOP: begin
					if (ph_q) begin
						if (!cnt_q[0]) begin
							freq_q <= ival_t'(fclamp[INTERNAL_BITS-1:0]);
							phase_q <= phase_q + filt_q;
						end else begin
							filt_q <= isat((p_q >>> Q24_SHIFT) + wide_t'(freq_q));
						end
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q[71:48] <= freq_q;
						if (!stereo) begin
							m_tdata_q[15:0]  <= to_out(aud_q);
							m_tdata_q[31:16] <= '0;
							m_tdata_q[47:32] <= '0;
						end else if (nullm) begin
							m_tdata_q[15:0]  <= to_out(audn_q);
							m_tdata_q[31:16] <= (mode_e == MODE_NULL_LSB) ? to_out(audn_q) : '0;
							m_tdata_q[47:32] <= (mode_e == MODE_NULL_USB) ? to_out(audn_q) : '0;
						end else begin
							m_tdata_q[15:0]  <= '0;
							m_tdata_q[31:16] <= to_out(aud_q);
							m_tdata_q[47:32] <= to_out(audu_q);
						end
					end
				end
				default: cur_q <= cur_q;
			endcase
		end
	end

	`SAMD_ASSERT_NEXT(a_accept_starts, clk, arst_n, s_tvalid && s_tready, (st_q == S_SINCOS) && !s_tready)
	`SAMD_ASSERT_SAME(a_chains_done, clk, arst_n, (st_q == S_CHAIN) && (st_d != S_CHAIN), chain_q == 2'd3)
	`SAMD_ASSERT_NEXT(a_out_hold, clk, arst_n, (st_q == S_DONE) && m_tvalid && !m_tready, st_q == S_DONE)
endmodule
`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for the synchronous AM demodulator: stream stimulus, APB setup, checks.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import samd_pkg::*;

	typedef struct packed {
		logic signed [15:0] in_q;
		logic signed [15:0] in_i;
	} iq_t;

	typedef struct packed {
		logic signed [23:0] freq_word;
		logic signed [15:0] out_right;
		logic signed [15:0] out_left;
		logic signed [15:0] out_mono;
	} audio_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 300;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [31:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [71:0] m_tdata;
	logic psel;
	logic penable;
	logic pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	synchronous_am_demodulator DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	logic [2:0] cfg_mode;
	logic cfg_fade;
	logic cfg_dc;
	longint cfg_gprop, cfg_gint, cfg_flimit, cfg_ffast, cfg_fslow;
	longint pll_phase, pll_freq, pll_filt;
	longint ap_a [24];
	longint ap_b [24];
	longint ap_c [24];
	longint ap_d [24];
	longint hold_i, hold_q;
	longint fade_avg [4];
	longint dc_mem [3];

	iq_t pending_iq [$];
	audio_t expected_audio [$];
	int mismatch_count;
	int idle_cycles;
	bit timed_out;
	bit stall_long;
	int burst_left, gap_left;

	localparam longint ATAN_TAB [20] = '{2097152, 1238021, 654136, 332050, 166669, 83416,
		41718, 20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};
	localparam longint EVEN_COEF [7] = '{-5506315, -12485126, -15485755, -16416346,
		-16678705, -16751362, -16773698};
	localparam longint ODD_COEF [7] = '{-1663005, -9489524, -14385911, -16091429,
		-16588294, -16726200, -16765178};

	function automatic longint clampw(longint v, int bits);
		longint hi;
		hi = (longint'(1) << (bits - 1)) - 1;
		return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
	endfunction

	function automatic longint sat24(longint v);
		return clampw(v, 24);
	endfunction

	function automatic void trig_of(longint ph, output longint c, output longint s);
		longint x, y, z, dx, dy;
		x = 2547003;
		y = 0;
		z = ph & 64'h3FFFFF;
		for (int i = 0; i < 20; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_TAB[i];
			end else begin
				x += dx; y -= dy; z += ATAN_TAB[i];
			end
		end
		case ((ph >> 22) & 3)
			0: begin c = x; s = y; end
			1: begin c = -y; s = x; end
			2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endfunction

	function automatic longint phase_of(longint y, longint x);
		longint z, dx, dy;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			z = (y >= 0) ? 8388608 : -8388608;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < 20; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += ATAN_TAB[i];
			end else begin
				x -= dx; y += dy; z -= ATAN_TAB[i];
			end
		end
		return sat24(z);
	endfunction

	function automatic longint run_allpass(ref longint t [24], input bit odd, input longint x);
		longint r, k;
		t[0] = x;
		for (int j = 0; j < 7; j++) begin
			k = 3 * j;
			t[k + 3] = sat24((((odd ? ODD_COEF[j] : EVEN_COEF[j]) * (t[k] - t[k + 5])) >>> 24)
				+ t[k + 2]);
		end
		r = t[21];
		for (int j = 23; j > 0; j--) t[j] = t[j - 1];
		return r;
	endfunction

	function automatic void smooth(ref longint m, input longint f, input longint x);
		m = sat24((f * m + (longint'(16777216) - f) * x) >>> 24);
	endfunction

	function automatic longint dc_remove(ref longint z1, input longint x);
		longint z0, y;
		z0 = sat24(x + ((longint'(16609444) * z1) >>> 24));
		y = sat24(z0 - z1);
		z1 = z0;
		return y;
	endfunction

	function automatic logic [15:0] scale_out(longint v);
		return 16'(clampw(v >>> 5, 16));
	endfunction

	function automatic audio_t demodulate(iq_t smp);
		longint ii, qq, c, s, ai, bi, aq, bq, ci, cq, lsb, usb;
		longint ai_ps, bi_ps, aq_ps, bq_ps, audio, audiou, audion, mono, left, right;
		longint det, del, fr;
		logic [2:0] m;
		audio_t r;
		ai_ps = 0; bi_ps = 0; aq_ps = 0; bq_ps = 0;
		audio = 0; audiou = 0; audion = 0; mono = 0; left = 0; right = 0;
		m = (cfg_mode == MODE_ALIAS) ? MODE_SYNC : cfg_mode;
		ii = longint'(smp.in_i) <<< 5;
		qq = longint'(smp.in_q) <<< 5;
		trig_of(pll_phase, c, s);
		ai = sat24((c * ii) >>> 22);
		bi = sat24((s * ii) >>> 22);
		aq = sat24((c * qq) >>> 22);
		bq = sat24((s * qq) >>> 22);
		if (m != MODE_SYNC && m != MODE_CQUAM) begin
			ai_ps = run_allpass(ap_a, 0, hold_i);
			bi_ps = run_allpass(ap_b, 1, bi);
			bq_ps = run_allpass(ap_c, 0, hold_q);
			aq_ps = run_allpass(ap_d, 1, aq);
			hold_i = ai;
			hold_q = bq;
		end
		ci = sat24(ai + bq);
		cq = sat24(aq - bi);
		lsb = sat24((ai_ps + bi_ps) - (aq_ps - bq_ps));
		usb = sat24((ai_ps - bi_ps) + (aq_ps + bq_ps));
		case (m)
			MODE_USB: audio = usb;
			MODE_LSB: audio = lsb;
			MODE_STEREO: begin audio = lsb; audiou = usb; end
			MODE_CQUAM: begin audio = sat24(ci + cq); audiou = sat24(ci - cq); end
			MODE_NULL_LSB: begin audio = lsb; audiou = usb; audion = sat24(lsb - usb); end
			MODE_NULL_USB: begin audio = lsb; audiou = usb; audion = sat24(usb - lsb); end
			default: audio = ci;
		endcase
		if (cfg_fade) begin
			smooth(fade_avg[0], cfg_ffast, audio);
			smooth(fade_avg[1], cfg_fslow, ci);
			audio = sat24(audio + fade_avg[1] - fade_avg[0]);
		end
		if (cfg_dc) audio = dc_remove(dc_mem[0], audio);
		if (m >= MODE_STEREO) begin
			if (cfg_fade) begin
				smooth(fade_avg[2], cfg_ffast, audiou);
				smooth(fade_avg[3], cfg_fslow, ci);
				audiou = sat24(audiou + fade_avg[3] - fade_avg[2]);
			end
			if (cfg_dc) audiou = dc_remove(dc_mem[1], audiou);
			if (m >= MODE_NULL_LSB) begin
				if (cfg_dc) audion = dc_remove(dc_mem[2], audion);
				mono = audion;
				if (m == MODE_NULL_LSB) left = audion;
				else right = audion;
			end else begin
				left = audio;
				right = audiou;
			end
		end else begin
			mono = audio;
		end
		det = phase_of(cq, ci);
		del = pll_filt;
		fr = pll_freq + ((cfg_gint * det) >>> 24);
		fr = fr > cfg_flimit ? cfg_flimit : (fr < -cfg_flimit ? -cfg_flimit : fr);
		pll_freq = fr;
		pll_filt = sat24(((cfg_gprop * det) >>> 24) + fr);
		pll_phase = (pll_phase + del) & 64'hFFFFFF;
		r.out_mono = scale_out(mono);
		r.out_left = scale_out(left);
		r.out_right = scale_out(right);
		r.freq_word = 24'(pll_freq);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d, expected %0d", what, got, want);
		mismatch_count++;
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// driver
	always @(negedge clk) begin
		if (s_tvalid && !s_tready) begin
			// hold
		end else if (pending_iq.size() == 0) begin
			s_tvalid <= 1'b0;
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			s_tvalid <= 1'b0;
		end else begin
			s_tvalid <= 1'b1;
			s_tdata <= pending_iq[0];
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 8);
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 150);
			end else begin
				burst_left <= burst_left - 1;
			end
		end
	end

	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			void'(pending_iq.pop_front());
			expected_audio.push_back(demodulate(s_tdata));
		end
	end

	// receiver stall pattern
	always @(negedge clk) begin
		if (stall_long) m_tready <= 1'b0;
		else m_tready <= ($urandom_range(0, 9) < 7);
	end

	// monitor
	always @(posedge clk) begin
		audio_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_audio.size() == 0) begin
				report_mismatch("unexpected beat", 0, 0);
			end else begin
				want = expected_audio.pop_front();
				if (got.out_mono !== want.out_mono)
					report_mismatch("out_mono", got.out_mono, want.out_mono);
				if (got.out_left !== want.out_left)
					report_mismatch("out_left", got.out_left, want.out_left);
				if (got.out_right !== want.out_right)
					report_mismatch("out_right", got.out_right, want.out_right);
				if (got.freq_word !== want.freq_word)
					report_mismatch("freq_word", got.freq_word, want.freq_word);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	task automatic write_reg(input logic [2:0] idx, input longint val);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {idx, 2'b00}; pwdata <= 32'(val);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_MODE: cfg_mode = val[2:0];
			REG_FADE: cfg_fade = val[0];
			REG_DC: cfg_dc = val[0];
			REG_GPROP: cfg_gprop = val & 64'hFFFFFF;
			REG_GINT: cfg_gint = val & 64'hFFFFFF;
			REG_FLIMIT: cfg_flimit = val & 64'h7FFFFF;
			REG_FFAST: cfg_ffast = val & 64'hFFFFFF;
			default: cfg_fslow = val & 64'hFFFFFF;
		endcase
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic drain;
		while ((pending_iq.size() != 0 || expected_audio.size() != 0) && !timed_out)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_random(input int n, input int amp);
		iq_t v;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 9) == 0) begin
				v = $urandom;
			end else begin
				v.in_i = 16'($signed($urandom_range(0, 2 * amp)) - amp);
				v.in_q = 16'($signed($urandom_range(0, 2 * amp)) - amp);
			end
			pending_iq.push_back(v);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		cfg_mode = MODE_SYNC; cfg_fade = 0; cfg_dc = 0;
		cfg_gprop = 0; cfg_gint = 0; cfg_flimit = 8388607; cfg_ffast = 0; cfg_fslow = 0;
		pll_phase = 0; pll_freq = 0; pll_filt = 0; hold_i = 0; hold_q = 0;
		foreach (ap_a[k]) begin
			ap_a[k] = 0; ap_b[k] = 0; ap_c[k] = 0; ap_d[k] = 0;
		end
		foreach (fade_avg[k]) fade_avg[k] = 0;
		foreach (dc_mem[k]) dc_mem[k] = 0;
		mismatch_count = 0; idle_cycles = 0; timed_out = 0; stall_long = 0;
		burst_left = 0; gap_left = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, zero vector, reset defaults
		pending_iq.push_back('{16'sh0000, 16'sh0000});
		pending_iq.push_back('{16'sh7FFF, 16'sh7FFF});
		pending_iq.push_back('{16'sh8000, 16'sh8000});
		pending_iq.push_back('{16'sh7FFF, 16'sh8000});
		pending_iq.push_back('{16'sh8000, 16'sh7FFF});
		pending_iq.push_back('{16'sh0000, 16'sh7FFF});
		pending_iq.push_back('{16'sh0000, 16'sh8000});
		pending_iq.push_back('{16'shFFFF, 16'sh0001});
		drain();
		write_reg(REG_GPROP, 24'hFFFFFF);
		write_reg(REG_GINT, 24'hFFFFFF);
		write_reg(REG_FLIMIT, 0);
		write_reg(REG_MODE, MODE_ALIAS);
		pending_iq.push_back('{16'sh4000, 16'sh1000});
		pending_iq.push_back('{16'shC000, 16'sh8000});
		drain();
		for (int md = MODE_USB; md <= MODE_NULL_USB; md++) begin
			write_reg(REG_MODE, md);
			pending_iq.push_back('{16'sh7FFF, 16'sh2000});
			pending_iq.push_back('{16'sh8000, 16'shE000});
			drain();
		end

		// random phases across configurations
		for (int ph = 0; ph < 16; ph++) begin
			write_reg(REG_MODE, (ph < 8) ? ph : $urandom_range(0, 7));
			write_reg(REG_FADE, $urandom_range(0, 1));
			write_reg(REG_DC, $urandom_range(0, 1));
			write_reg(REG_GPROP, (ph == 3) ? 24'hFFFFFF : $urandom_range(0, 24'h3FFFFF));
			write_reg(REG_GINT, (ph == 5) ? 24'hFFFFFF : $urandom_range(0, 24'h0FFFFF));
			write_reg(REG_FLIMIT, (ph == 7) ? 0 : ((ph % 3 == 0) ? 23'h7FFFFF :
				$urandom_range(0, 23'h7FFFFF)));
			write_reg(REG_FFAST, (ph == 2) ? 0 : ((ph == 4) ? 24'hFFFFFF : $urandom));
			write_reg(REG_FSLOW, (ph == 6) ? 0 : ((ph == 9) ? 24'hFFFFFF : $urandom));
			if (ph == 8) begin
				queue_random(20, 32767);
				fork
					begin
						stall_long = 1;
						repeat (3000) @(posedge clk);
						stall_long = 0;
					end
				join_none
			end
			queue_random(66, (ph % 4 == 0) ? 2000 : 32767);
			drain();
		end

		if (timed_out) begin
			// watchdog has ended the run
		end else begin
			if (mismatch_count == 0) $display("All tests passed");
			else $display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out <= 1;
			$display("Some tests failed");
			$finish;
		end
	end
endmodule
`default_nettype wire

### filelist.f
+incdir+rtl
rtl/samd_pkg.sv
rtl/synchronous_am_demodulator.sv
test/tb_top.sv
